@@ hdl/cdg_pkg.sv @@
// ----------------------------------------------------------------------------
// cdg_pkg: shared definitions for the central difference gradient block
// Frame limits, field widths, register indexes and the records passed
// between the line store stage and the result expander.
// ----------------------------------------------------------------------------
package cdg_pkg;

	// Frame limits and field widths.
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int PIX_W      = 8;
	localparam int DIM_W      = 12;
	localparam int COORD_W    = 11;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);

	// Configuration port.
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);
	localparam logic [DIM_W-1:0] MIN_DIM          = DIM_W'(3);

	// Depth of the record queue in front of the expander.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One line store word: the row two above and the row one above.
	typedef struct packed {
		logic [PIX_W-1:0] far;
		logic [PIX_W-1:0] near;
	} line_word_t;

	// Gradient of one interior position and the block of positions it covers.
	typedef struct packed {
		logic [PIX_W-1:0]   grad_x;
		logic [PIX_W-1:0]   grad_y;
		logic [COORD_W-1:0] x_lo;
		logic [COORD_W-1:0] x_hi;
		logic [COORD_W-1:0] y_lo;
		logic [COORD_W-1:0] y_hi;
	} grad_rec_t;

	typedef struct packed {
		logic      valid;
		grad_rec_t rec;
	} grad_push_t;

endpackage

@@ hdl/cdg_if.sv @@
// ----------------------------------------------------------------------------
// cdg_if: channel interfaces of the central difference gradient block
// Pixel input, gradient output and configuration write channels, each with
// valid, ready and payload.
// ----------------------------------------------------------------------------
interface cdg_pixel_if import cdg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface cdg_grad_if import cdg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   grad_x;
	logic [PIX_W-1:0]   grad_y;
	logic [COORD_W-1:0] col_pos;
	logic [COORD_W-1:0] row_pos;
	logic               run_last;

	modport source (output valid, output grad_x, output grad_y, output col_pos,
		output row_pos, output run_last, input ready);
	modport sink   (input valid, input grad_x, input grad_y, input col_pos,
		input row_pos, input run_last, output ready);
endinterface

interface cdg_cfg_if import cdg_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/cdg_ram.sv @@
// ----------------------------------------------------------------------------
// cdg_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cdg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/cdg_window.sv @@
// ----------------------------------------------------------------------------
// cdg_window: frame position, line store and gradient arithmetic
// Tracks the raster position, reads and rewrites the two-row line store
// once per pixel, and forms the gradient record of each interior position.
// ----------------------------------------------------------------------------
module cdg_window import cdg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	cdg_pixel_if.sink         pixels,
	cdg_cfg_if.sink           cfg,
	input  logic [QCNT_W-1:0] q_used,
	output grad_push_t        push
);

	localparam logic [PIX_W:0] GRAD_BIAS = (PIX_W+1)'(255);

	// Clamp a configured dimension to the supported range.
	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] res;
		if (v < MIN_DIM) begin
			res = MIN_DIM;
		end else if (v > hi) begin
			res = hi;
		end else begin
			res = v;
		end
		return res;
	endfunction

	// Central difference encoded as (a - b + 255) / 2.
	function automatic logic [PIX_W-1:0] central(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		logic [PIX_W:0] sum;
		sum = {1'b0, a} + GRAD_BIAS - {1'b0, b};
		return sum[PIX_W:1];
	endfunction

	logic [DIM_W-1:0]   fw_q, fh_q, w_eff, h_eff, w_m1, w_m2, h_m1, h_m2;
	logic [COORD_W-1:0] col_q, row_q;
	logic [DIM_W-1:0]   row_inc, col_next_ext, row_next_ext;
	logic               col_wrap, col_next_wrap;
	logic [COORD_W-1:0] col_cur, row_cur, col_nxt, row_nxt;
	logic [QCNT_W-1:0]  in_flight;
	logic               accept;

	logic               valid_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [COORD_W-1:0] col_s1, row_s1;
	logic [PIX_W-1:0]   tap_one_q, tap_two_q, prev_q, above_q;
	line_word_t         rd_word, wr_word;
	logic [COORD_W-1:0] xi, yi;

	// Configuration registers; always ready.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FRAME_WIDTH_RST;
			fh_q <= FRAME_HEIGHT_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_FRAME_WIDTH:  fw_q <= cfg.data;
				REG_FRAME_HEIGHT: fh_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign w_eff = sat_dim(fw_q, DIM_W'(MAX_WIDTH));
	assign h_eff = sat_dim(fh_q, DIM_W'(MAX_HEIGHT));
	assign w_m1  = w_eff - DIM_W'(1);
	assign w_m2  = w_eff - DIM_W'(2);
	assign h_m1  = h_eff - DIM_W'(1);
	assign h_m2  = h_eff - DIM_W'(2);

	// Position of this pixel, and of the next one, after row and frame wrap.
	always_comb begin
		col_wrap      = {1'b0, col_q} >= w_eff;
		col_cur       = col_wrap ? '0 : col_q;
		row_inc       = {1'b0, row_q} + DIM_W'(col_wrap);
		row_cur       = (row_inc >= h_eff) ? '0 : row_inc[COORD_W-1:0];
		col_next_ext  = {1'b0, col_cur} + DIM_W'(1);
		col_next_wrap = col_next_ext >= w_eff;
		col_nxt       = col_next_wrap ? '0 : col_next_ext[COORD_W-1:0];
		row_next_ext  = {1'b0, row_cur} + DIM_W'(col_next_wrap);
		row_nxt       = (row_next_ext >= h_eff) ? '0 : row_next_ext[COORD_W-1:0];
	end

	// Take a pixel only when the record queue has room for everything in flight.
	assign in_flight    = q_used + QCNT_W'(valid_s1);
	assign pixels.ready = in_flight < QCNT_W'(QDEPTH);
	assign accept       = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixels.pixel;
			col_s1 <= col_cur;
			row_s1 <= row_cur;
		end
	end

	// Line store: read the column at accept, write it back in the following cycle.
	// The old near row moves to the far row and the new pixel becomes near.
	// A column is read again only a full row later, so no forwarding is needed.
	assign wr_word.far  = rd_word.near;
	assign wr_word.near = pix_s1;

	cdg_ram #(
		.WIDTH ($bits(line_word_t)),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (ADDR_W'(col_s1)),
		.wdata (wr_word),
		.re    (accept),
		.raddr (ADDR_W'(col_cur)),
		.rdata (rd_word)
	);

	// Neighbor taps: the row above two columns back, the pixel to the left
	// and the row two above at the previous column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_one_q <= '0;
			tap_two_q <= '0;
			prev_q    <= '0;
			above_q   <= '0;
		end else if (valid_s1) begin
			tap_two_q <= tap_one_q;
			tap_one_q <= rd_word.near;
			prev_q    <= pix_s1;
			above_q   <= rd_word.far;
		end
	end

	// Gradient record of the interior position one up and one left.
	assign xi = col_s1 - COORD_W'(1);
	assign yi = row_s1 - COORD_W'(1);

	always_comb begin
		push.valid      = valid_s1 && (col_s1 >= COORD_W'(2)) && (row_s1 >= COORD_W'(2));
		push.rec.grad_x = central(rd_word.near, tap_two_q);
		push.rec.grad_y = central(prev_q, above_q);
		push.rec.x_lo   = (xi == COORD_W'(1)) ? '0 : xi;
		push.rec.x_hi   = ({1'b0, xi} == w_m2) ? w_m1[COORD_W-1:0] : xi;
		push.rec.y_lo   = (yi == COORD_W'(1)) ? '0 : yi;
		push.rec.y_hi   = ({1'b0, yi} == h_m2) ? h_m1[COORD_W-1:0] : yi;
	end

`ifndef SYNTHESIS
	// A write-back never targets the column being read in the same cycle.
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && accept |-> col_cur != col_s1)
		else $error("line store read and write-back hit the same column");

	// Pixels in flight never exceed the record queue capacity.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight <= QCNT_W'(QDEPTH))
		else $error("more pixels in flight than queue entries");
`endif

endmodule

@@ hdl/cdg_expand.sv @@
// ----------------------------------------------------------------------------
// cdg_expand: record queue and result expander
// Queues gradient records and emits one result per covered position,
// through an output register.
// ----------------------------------------------------------------------------
module cdg_expand import cdg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  grad_push_t        push,
	output logic [QCNT_W-1:0] q_used,
	cdg_grad_if.source        grads
);

	grad_rec_t          rec_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  used_q;
	logic               start_q;
	logic [COORD_W-1:0] x_q, y_q;

	logic               out_valid_q, run_last_q;
	logic [PIX_W-1:0]   grad_x_q, grad_y_q;
	logic [COORD_W-1:0] col_pos_q, row_pos_q;

	grad_rec_t          head;
	logic [COORD_W-1:0] cur_x, cur_y;
	logic               done_x, done_y, last, fire, pop;

	// Current position inside the head record's block.
	assign head   = rec_q[rd_ptr_q];
	assign cur_x  = start_q ? head.x_lo : x_q;
	assign cur_y  = start_q ? head.y_lo : y_q;
	assign done_x = cur_x == head.x_hi;
	assign done_y = cur_y == head.y_hi;
	assign last   = done_x && done_y;
	assign fire   = (used_q != '0) && (!out_valid_q || grads.ready);
	assign pop    = fire && last;
	assign q_used = used_q;

	// Record queue.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			rec_q[wr_ptr_q] <= push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			used_q   <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			used_q <= used_q + QCNT_W'(push.valid) - QCNT_W'(pop);
		end
	end

	// Scan the block row by row, one position per beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else if (fire) begin
			start_q <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (done_x) begin
				x_q <= head.x_lo;
				y_q <= cur_y + COORD_W'(1);
			end else begin
				x_q <= cur_x + COORD_W'(1);
				y_q <= cur_y;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (grads.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			grad_x_q   <= head.grad_x;
			grad_y_q   <= head.grad_y;
			col_pos_q  <= cur_x;
			row_pos_q  <= cur_y;
			run_last_q <= last;
		end
	end

	assign grads.valid    = out_valid_q;
	assign grads.grad_x   = grad_x_q;
	assign grads.grad_y   = grad_y_q;
	assign grads.col_pos  = col_pos_q;
	assign grads.row_pos  = row_pos_q;
	assign grads.run_last = run_last_q;

`ifndef SYNTHESIS
	// A record never arrives at a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && !pop |-> used_q != QCNT_W'(QDEPTH))
		else $error("record queue overflow");

	// A scan in progress stays inside the head record's block.
	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !start_q |-> (x_q <= head.x_hi) && (y_q <= head.y_hi))
		else $error("result scan left its block");
`endif

endmodule

@@ hdl/central_difference_gradient.sv @@
// ----------------------------------------------------------------------------
// central_difference_gradient: streaming 3x3 central difference gradient
// Accepts raster-order grayscale pixels and emits horizontal and vertical
// gradients with their coordinates, border positions clamped to the interior.
// ----------------------------------------------------------------------------
// A pixel is taken every cycle while results keep pace: each pixel reads and
// rewrites one 16-bit word of a single 2048-entry line store (rows one and two
// above), so the store's one read and one write port set the one-pixel-per-
// cycle rate. Each result leaves through the output register at one beat per
// cycle while the sink is ready, so a pixel that closes a border position
// occupies the output for all of its results: two or three on an edge, up to
// nine at a corner, none in the first two rows and columns. A four-record
// queue absorbs these bursts. With the queue empty, a pixel's first result
// goes through the input stage, the queue and the output register in turn.
// The line store needs no clearing after reset. Frame width and height are
// clamped to 3..2048 and should be written only while the block is idle.
module central_difference_gradient import cdg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cdg_pixel_if.sink  pixels,
	cdg_cfg_if.sink    cfg,
	cdg_grad_if.source grads
);

	grad_push_t        push;
	logic [QCNT_W-1:0] q_used;

	// Position tracking, line store and arithmetic.
	cdg_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels),
		.cfg    (cfg),
		.q_used (q_used),
		.push   (push)
	);

	// Border expansion and output register.
	cdg_expand u_expand (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.q_used (q_used),
		.grads  (grads)
	);

endmodule
